### src/sha1_pkg.sv
package sha1_pkg;

  localparam int WORD_W  = 32;
  localparam int NUM_H   = 5;
  localparam int NUM_W   = 16;
  localparam int CNT_W   = 61;
  localparam int FILL_W  = 6;
  localparam int ROUND_W = 7;
  localparam int OUT_W   = 3;

  localparam logic [WORD_W-1:0] H_INIT [NUM_H] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K_PH0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_PH1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_PH2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_PH3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [ROUND_W-1:0] ROUND_PH1  = 7'd20;
  localparam logic [ROUND_W-1:0] ROUND_PH2  = 7'd40;
  localparam logic [ROUND_W-1:0] ROUND_PH3  = 7'd60;
  localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

  localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;
  localparam logic [FILL_W-1:0] FILL_FULL = 6'd63;

  localparam logic [OUT_W-1:0] OUT_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
  } work_t;

endpackage

### src/sha1_round.sv
module sha1_round
  import sha1_pkg::*;
(
  input  work_t               work_in,
  input  logic [WORD_W-1:0]   sched_word,
  input  logic [ROUND_W-1:0]  round_idx,
  output work_t               work_out
);

  logic [WORD_W-1:0] f;
  logic [WORD_W-1:0] k;
  logic [WORD_W-1:0] t;

  always_comb begin
    if (round_idx < ROUND_PH1) begin
      f = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
      k = K_PH0;
    end else if (round_idx < ROUND_PH2) begin
      f = work_in.b ^ work_in.c ^ work_in.d;
      k = K_PH1;
    end else if (round_idx < ROUND_PH3) begin
      f = (work_in.b & work_in.c) | (work_in.b & work_in.d) | (work_in.c & work_in.d);
      k = K_PH2;
    end else begin
      f = work_in.b ^ work_in.c ^ work_in.d;
      k = K_PH3;
    end
    t = {work_in.a[26:0], work_in.a[31:27]} + f + work_in.e + k + sched_word;
    work_out.a = t;
    work_out.b = work_in.a;
    work_out.c = {work_in.b[1:0], work_in.b[31:2]};
    work_out.d = work_in.c;
    work_out.e = work_in.d;
  end

endmodule

### src/sha1_hash_engine.sv
// Each accepted word with a byte shifts it into the block; a word that fills the block
// starts a compression (80 rounds of the shared round unit, then one chaining add).
// On the last word the padding bytes enter one a cycle, followed by one or two
// compressions, then five digest words are offered one a cycle while out_tready is high.
// Synchronous active-low reset restores the initial chaining words and clears
// the byte count and sequencer; the message schedule and round words are not reset.
module sha1_hash_engine
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word[31:0]
  output logic        out_tlast
);

  state_t               state_r, state_nxt;
  logic [WORD_W-1:0]    chain_r [NUM_H];
  logic [WORD_W-1:0]    chain_nxt [NUM_H];
  logic [WORD_W-1:0]    sched_r [NUM_W];
  logic [WORD_W-1:0]    sched_nxt [NUM_W];
  work_t                work_r, work_nxt, work_rnd;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [ROUND_W-1:0]   round_r, round_nxt;
  logic [OUT_W-1:0]     oidx_r, oidx_nxt;
  logic                 pend_r, pend_nxt;
  logic                 mark_r, mark_nxt;
  logic                 len_ok_r, len_ok_nxt;
  logic                 final_r, final_nxt;

  logic                 shift_byte;
  logic [7:0]           new_byte;
  logic [63:0]          bit_len;
  logic [5:0]           len_sh;
  logic [7:0]           len_byte;

  sha1_round u_round (
    .work_in    (work_r),
    .sched_word (sched_r[0]),
    .round_idx  (round_r),
    .work_out   (work_rnd)
  );

  assign bit_len   = {count_r, 3'b000};
  assign len_sh    = {~fill_r[2:0], 3'b000};
  assign len_byte  = bit_len[len_sh +: 8];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = chain_r[oidx_r];
  assign out_tlast  = (oidx_r == OUT_LAST);

  always_comb begin
    state_nxt  = state_r;
    chain_nxt  = chain_r;
    sched_nxt  = sched_r;
    work_nxt   = work_r;
    count_nxt  = count_r;
    fill_nxt   = fill_r;
    round_nxt  = round_r;
    oidx_nxt   = oidx_r;
    pend_nxt   = pend_r;
    mark_nxt   = mark_r;
    len_ok_nxt = len_ok_r;
    final_nxt  = final_r;
    shift_byte = 1'b0;
    new_byte   = in_tdata;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            shift_byte = 1'b1;
            count_nxt  = count_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
            if (fill_r == FILL_FULL) begin
              pend_nxt  = in_tlast;
              state_nxt = ST_ROUND;
              work_nxt  = '{a: chain_r[0], b: chain_r[1], c: chain_r[2],
                            d: chain_r[3], e: chain_r[4]};
            end else if (in_tlast) begin
              state_nxt = ST_PAD;
            end
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_byte = 1'b1;
        fill_nxt   = fill_r + 1'b1;
        if (!mark_r) begin
          new_byte   = PAD_MARK;
          mark_nxt   = 1'b1;
          len_ok_nxt = (fill_r < FILL_LEN);
        end else if (len_ok_r && (fill_r >= FILL_LEN)) begin
          new_byte = len_byte;
        end else begin
          new_byte = 8'h00;
        end
        if (fill_r == FILL_FULL) begin
          final_nxt  = len_ok_r;
          len_ok_nxt = 1'b1;
          pend_nxt   = 1'b1;
          state_nxt  = ST_ROUND;
          work_nxt   = '{a: chain_r[0], b: chain_r[1], c: chain_r[2],
                         d: chain_r[3], e: chain_r[4]};
        end
      end
      ST_ROUND: begin
        work_nxt = work_rnd;
        for (int i = 0; i < NUM_W - 1; i++) begin
          sched_nxt[i] = sched_r[i+1];
        end
        sched_nxt[NUM_W-1] = {sched_r[13][30:0] ^ sched_r[8][30:0] ^
                              sched_r[2][30:0] ^ sched_r[0][30:0],
                              sched_r[13][31] ^ sched_r[8][31] ^
                              sched_r[2][31] ^ sched_r[0][31]};
        if (round_r == ROUND_LAST) begin
          round_nxt = '0;
          state_nxt = ST_ADD;
        end else begin
          round_nxt = round_r + 1'b1;
        end
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        chain_nxt[4] = chain_r[4] + work_r.e;
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (pend_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          if (oidx_r == OUT_LAST) begin
            oidx_nxt   = '0;
            chain_nxt  = H_INIT;
            count_nxt  = '0;
            fill_nxt   = '0;
            pend_nxt   = 1'b0;
            mark_nxt   = 1'b0;
            len_ok_nxt = 1'b0;
            final_nxt  = 1'b0;
            state_nxt  = ST_IDLE;
          end else begin
            oidx_nxt = oidx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (shift_byte) begin
      for (int i = 0; i < NUM_W - 1; i++) begin
        sched_nxt[i] = {sched_r[i][23:0], sched_r[i+1][31:24]};
      end
      sched_nxt[NUM_W-1] = {sched_r[NUM_W-1][23:0], new_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      chain_r  <= H_INIT;
      count_r  <= '0;
      fill_r   <= '0;
      round_r  <= '0;
      oidx_r   <= '0;
      pend_r   <= 1'b0;
      mark_r   <= 1'b0;
      len_ok_r <= 1'b0;
      final_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      chain_r  <= chain_nxt;
      count_r  <= count_nxt;
      fill_r   <= fill_nxt;
      round_r  <= round_nxt;
      oidx_r   <= oidx_nxt;
      pend_r   <= pend_nxt;
      mark_r   <= mark_nxt;
      len_ok_r <= len_ok_nxt;
      final_r  <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sched_r <= sched_nxt;
    work_r  <= work_nxt;
  end

endmodule

### tb/sv/tb_sha1_hash_engine.sv
`timescale 1ns / 100ps

module tb_sha1_hash_engine;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] SHA1_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] DIGEST_A     = 160'h86f7e437faa5a7fce15d1ddcb9eaeaea377667b8;
  localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  typedef struct packed {
    logic [7:0]   data;
    logic         has;
    logic         last;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_out_t;

  localparam int N_DIRECTED = 16;
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'hA5, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
    '{8'hFF, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'h61, 1'b1, 1'b1, 1'b1, DIGEST_A},
    '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h7F, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h5A, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hC3, 1'b0, 1'b1, 1'b0, 160'h0}
  };

  localparam int N_EDGE_LENGTHS = 4;
  localparam int EDGE_LENGTHS [N_EDGE_LENGTHS] = '{55, 56, 63, 64};
  localparam int ITEM_TARGET = 430;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [31:0] out_tdata;
  logic        out_tlast;

  logic [31:0] chain_h [5];
  logic [7:0]  msg_block [64];
  logic [60:0] msg_len;

  digest_out_t digest_due [$];
  int          bad_words   = 0;
  int          items_sent  = 0;
  int          stall_left  = 0;
  logic        steady_phase = 1'b0;
  logic        gappy        = 1'b1;

  sha1_hash_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("sha1_hash_engine test failed");
    $finish;
  end

  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, sum, x;
    int r;
    for (r = 0; r < 16; r++) begin
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        x = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
        w[r & 15] = {x[30:0], x[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = SHA1_K[0];
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = SHA1_K[1];
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = SHA1_K[2];
      end else begin
        f = b ^ c ^ d;
        k = SHA1_K[3];
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
    chain_h[4] = chain_h[4] + e;
  endfunction

  // Returns 1 when the word closes a message, with the digest h0 in the top bits.
  function automatic logic absorb_word(input logic [7:0] b, input logic hb, input logic lst,
                                       output logic [159:0] digest);
    int pos;
    int i;
    logic [63:0] bits;
    digest = '0;
    if (hb) begin
      pos = int'(msg_len[5:0]);
      msg_block[pos] = b;
      msg_len = msg_len + 61'd1;
      if (pos == 63) sha1_compress();
    end
    if (!lst) return 1'b0;
    pos = int'(msg_len[5:0]);
    msg_block[pos] = 8'h80;
    pos = pos + 1;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos = pos + 1;
      end
      sha1_compress();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos = pos + 1;
    end
    bits = {msg_len, 3'b000};
    for (i = 0; i < 8; i++) msg_block[56 + i] = bits[63 - 8*i -: 8];
    sha1_compress();
    digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
    for (i = 0; i < 5; i++) chain_h[i] = SHA1_IV[i];
    msg_len = '0;
    return 1'b1;
  endfunction

  task automatic put_word(input logic [7:0] b, input logic hb, input logic lst,
                          input logic use_known, input logic [159:0] known);
    logic [159:0] digest;
    int i;
    if (!steady_phase && gappy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= hb;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (absorb_word(b, hb, lst, digest)) begin
      if (use_known) digest = known;
      for (i = 0; i < 5; i++) digest_due.push_back({digest[159 - 32*i -: 32], i == 4});
    end
  endtask

  task automatic send_message(input int n_bytes);
    logic byte_on_last;
    int i;
    gappy = $urandom_range(0, 2) != 0;
    byte_on_last = (n_bytes > 0) && ($urandom_range(0, 3) != 0);
    for (i = 0; i < n_bytes - int'(byte_on_last); i++) begin
      if ($urandom_range(0, 9) == 0) put_word(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
      put_word(8'($urandom), 1'b1, 1'b0, 1'b0, '0);
    end
    put_word(8'($urandom), byte_on_last, 1'b1, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n || steady_phase) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_digest
    digest_out_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_due.size() == 0) begin
        $error("digest_word: expected none, got %h", out_tdata);
        bad_words++;
      end else begin
        due = digest_due.pop_front();
        if (out_tdata !== due.word) begin
          $error("digest_word: expected %h, got %h", due.word, out_tdata);
          bad_words++;
        end
        if (out_tlast !== due.last) begin
          $error("word_last: expected %b, got %b", due.last, out_tlast);
          bad_words++;
        end
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < 5; i++) chain_h[i] = SHA1_IV[i];
    for (i = 0; i < 64; i++) msg_block[i] = 8'h00;
    msg_len = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++) begin
      put_word(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].has, DIRECTED_ROWS[i].last,
               DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].digest);
    end

    // Hold the sender off until the whole digest backlog has drained.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digest_due.size() != 0) @(posedge clk);

    for (i = 0; i < N_EDGE_LENGTHS; i++) send_message(EDGE_LENGTHS[i]);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - 50) steady_phase <= 1'b1;
      if ($urandom_range(0, 7) == 0) send_message($urandom_range(40, 70));
      else send_message($urandom_range(0, 24));
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digest_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (bad_words == 0) begin
      $display("sha1_hash_engine test passed");
    end else begin
      $display("sha1_hash_engine test failed");
    end
    $finish;
  end

endmodule
